// File: hdl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and codes for the labelled shortest path block
// Field widths, command and operation codes, settle labels, queue word.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 32;
  localparam int DIST_W   = 48;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_HAZ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

  // classified operations carried through the queue
  typedef logic [1:0] op_t;
  localparam op_t OP_HAZ     = 2'd0;
  localparam op_t OP_EDGE    = 2'd1;
  localparam op_t OP_RUN     = 2'd2;
  localparam op_t OP_RUN_BAD = 2'd3;

  // settle labels
  typedef logic [1:0] label_t;
  localparam label_t LABEL_NONE  = 2'd0;
  localparam label_t LABEL_START = 2'd1;
  localparam label_t LABEL_HAZ   = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    op_t                 op;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
  } msp_word_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    msp_word_t word;
  } msp_q_t;

endpackage

// File: hdl/msp_if.sv
// ----------------------------------------------------------------------------
// msp_if: request and response channels
// Valid/ready channels carrying command words in and results out.
// ----------------------------------------------------------------------------
interface msp_req_if import msp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, cmd, node_a, node_b, weight, input ready);
  modport sink   (input valid, cmd, node_a, node_b, weight, output ready);
endinterface

interface msp_rsp_if import msp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reachable;
  logic [DIST_W-1:0] distance;
  logic              overflow;

  modport source (output valid, reachable, distance, overflow, input ready);
  modport sink   (input valid, reachable, distance, overflow, output ready);
endinterface

// File: hdl/multi_source_labelled_shortest_path.sv
// ----------------------------------------------------------------------------
// multi_source_labelled_shortest_path: labelled multi-source Dijkstra search
// Load words are taken one per cycle, while the queue has room, into a
// four-word queue; a hazard load marks its node, an edge load stores both
// list entries. A run scans every node to push the hazards, pushes the start,
// then pops the heap and scans each popped node's edges, paced by the
// registered-read memories. Reset (synchronous) and every result start a
// clearing pass over all nodes.
module multi_source_labelled_shortest_path import msp_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int EDGES      = 4096,
  parameter int HEAP_SLOTS = 16384
) (
  input  logic      clk,
  input  logic      rst,
  msp_req_if.sink   req,
  msp_rsp_if.source rsp
);

  logic      wr;
  logic      full;
  logic      deq;
  msp_word_t word;
  msp_q_t    head;

  msp_front #(.NODES(NODES)) u_front (
    .req  (req),
    .full (full),
    .wr   (wr),
    .word (word)
  );

  msp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .wdata (word),
    .full  (full),
    .rd    (deq),
    .head  (head)
  );

  msp_back #(
    .NODES      (NODES),
    .EDGES      (EDGES),
    .HEAP_SLOTS (HEAP_SLOTS)
  ) u_back (
    .clk (clk),
    .rst (rst),
    .q   (head),
    .deq (deq),
    .rsp (rsp)
  );

endmodule

// File: hdl/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front: request classifier
// Checks node ranges and turns each command into a queue operation; drops
// loads that do nothing.
// ----------------------------------------------------------------------------
module msp_front import msp_pkg::*; #(
  parameter int NODES = 1024
) (
  msp_req_if.sink   req,
  input  logic      full,
  output logic      wr,
  output msp_word_t word
);

  logic a_ok;
  logic b_ok;
  logic keep;

  assign a_ok = 32'(req.node_a) < NODES;
  assign b_ok = 32'(req.node_b) < NODES;

  // classify the command
  always_comb begin
    keep    = 1'b0;
    word.op = OP_HAZ;
    word.a  = req.node_a;
    word.b  = req.node_b;
    word.w  = req.weight;
    unique case (req.cmd)
      CMD_HAZ: begin
        keep    = a_ok;
        word.op = OP_HAZ;
      end
      CMD_EDGE: begin
        keep    = a_ok && b_ok;
        word.op = OP_EDGE;
      end
      CMD_RUN: begin
        keep    = 1'b1;
        word.op = (a_ok && b_ok) ? OP_RUN : OP_RUN_BAD;
      end
      default: keep = 1'b0;
    endcase
  end

  assign req.ready = !full;
  assign wr        = req.valid && !full && keep;

endmodule

// File: hdl/msp_fifo.sv
// ----------------------------------------------------------------------------
// msp_fifo: short word queue between front and back
// Four-entry register queue; head word is shown with its valid bit.
// ----------------------------------------------------------------------------
module msp_fifo import msp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  msp_word_t wdata,
  output logic      full,
  input  logic      rd,
  output msp_q_t    head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  msp_word_t     slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full       = count == (PW+1)'(DEPTH);
  assign head.valid = count != '0;
  assign head.word  = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("queue written while full");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst) !(rd && !head.valid))
    else $error("queue read while empty");

endmodule

// File: hdl/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back: graph store and search sequencer
// Builds adjacency lists, runs the labelled Dijkstra search over a binary
// heap in memory, registers the result and sweeps the stores clear.
// ----------------------------------------------------------------------------
module msp_back import msp_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int EDGES      = 4096,
  parameter int HEAP_SLOTS = 16384
) (
  input  logic   clk,
  input  logic   rst,
  input  msp_q_t q,
  output logic   deq,
  msp_rsp_if.source rsp
);

  localparam int NW        = $clog2(NODES);
  localparam int ADJ_SLOTS = 2 * EDGES;
  localparam int AW        = $clog2(ADJ_SLOTS);
  localparam int HW        = $clog2(HEAP_SLOTS);

  typedef logic [NW-1:0] node_t;
  typedef struct packed {
    logic [DIST_W-1:0] dval;
    logic              haz;
    node_t             node;
  } heap_t;

  // sequencer states
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_EDGE1   = 5'd2;
  localparam logic [4:0] S_EDGE2   = 5'd3;
  localparam logic [4:0] S_EDGE3   = 5'd4;
  localparam logic [4:0] S_EDGE4   = 5'd5;
  localparam logic [4:0] S_INIT_RD = 5'd6;
  localparam logic [4:0] S_INIT_CK = 5'd7;
  localparam logic [4:0] S_INIT_NX = 5'd8;
  localparam logic [4:0] S_INIT_ST = 5'd9;
  localparam logic [4:0] S_TOP     = 5'd10;
  localparam logic [4:0] S_POP0    = 5'd11;
  localparam logic [4:0] S_X1      = 5'd12;
  localparam logic [4:0] S_X2      = 5'd13;
  localparam logic [4:0] S_E1      = 5'd14;
  localparam logic [4:0] S_E2      = 5'd15;
  localparam logic [4:0] S_E3      = 5'd16;
  localparam logic [4:0] S_FIN1    = 5'd17;
  localparam logic [4:0] S_FIN2    = 5'd18;
  localparam logic [4:0] S_PUSH    = 5'd19;
  localparam logic [4:0] S_UP      = 5'd20;
  localparam logic [4:0] S_UPW     = 5'd21;
  localparam logic [4:0] S_POP     = 5'd22;
  localparam logic [4:0] S_POP1    = 5'd23;
  localparam logic [4:0] S_DN      = 5'd24;
  localparam logic [4:0] S_DNW     = 5'd25;

  localparam node_t V_LAST = NW'(NODES - 1);

  // heap order: distance, then hazard first, then lower node
  function automatic logic ahead(heap_t p, heap_t r);
    logic res;
    if (p.dval != r.dval) res = p.dval < r.dval;
    else if (p.haz != r.haz) res = p.haz;
    else res = p.node < r.node;
    return res;
  endfunction

  // memories
  node_t               adj_node_mem [ADJ_SLOTS];
  logic [WEIGHT_W-1:0] adj_w_mem    [ADJ_SLOTS];
  logic [AW:0]         link_mem     [ADJ_SLOTS];
  logic [AW:0]         head_mem     [NODES];
  logic [AW:0]         tail_mem     [NODES];
  logic                hz_mem       [NODES];
  logic [DIST_W-1:0]   best_mem     [NODES];
  label_t              st_mem       [NODES];
  heap_t               heap_mem     [HEAP_SLOTS];

  // memory controls
  logic                adj_we;
  logic [AW-1:0]       adj_addr;
  node_t               adj_node_wd;
  node_t               adj_node_rd;
  logic [WEIGHT_W-1:0] adj_w_rd;
  logic                link_we;
  logic [AW-1:0]       link_addr;
  logic [AW:0]         link_wd;
  logic [AW:0]         link_rd;
  logic                head_we;
  logic                tail_we;
  node_t               head_addr;
  logic [AW:0]         head_wd;
  logic [AW:0]         head_rd;
  logic [AW:0]         tail_rd;
  logic                hz_we;
  node_t               hz_addr;
  logic                hz_wd;
  logic                hz_rd;
  logic                best_we;
  node_t               best_addr;
  logic [DIST_W-1:0]   best_wd;
  logic [DIST_W-1:0]   best_rd;
  logic                st_we;
  node_t               st_addr;
  label_t              st_wd;
  label_t              st_rd;
  logic                hp_we;
  logic [HW-1:0]       hp_waddr;
  heap_t               hp_wd;
  logic [HW-1:0]       hp_ra0;
  logic [HW-1:0]       hp_ra1;
  heap_t               hp_rd0;
  heap_t               hp_rd1;

  // sequencer registers
  logic [4:0]          state;
  logic [4:0]          ret;
  node_t               v;
  logic [AW:0]         ecnt;
  logic [HW:0]         hsize;
  logic                ovf;
  node_t               qa;
  node_t               qb;
  logic [WEIGHT_W-1:0] qw;
  logic                bad;
  node_t               x;
  logic                xh;
  logic [DIST_W-1:0]   dx;
  logic [AW:0]         e;
  node_t               tnode;
  logic [DIST_W-1:0]   sum;
  heap_t               newe;
  logic [HW-1:0]       hole;
  heap_t               cur;
  logic                ovalid;
  logic                oreach;
  logic [DIST_W-1:0]   odist;
  logic                oovf;

  // derived values
  logic [AW:0]         ep1;
  logic [AW:0]         ep2;
  logic [AW:0]         e_dec;
  logic [AW:0]         tail_dec;
  logic [DIST_W:0]     sum_w;
  logic [DIST_W-1:0]   sum_sat;
  logic [HW-1:0]       parent;
  logic [HW+1:0]       l2;
  logic [HW+1:0]       r2;
  logic                l_ok;
  logic                r_ok;
  logic [HW:0]         hsize_dec;
  logic                use_l;
  logic                use_r;
  heap_t               cand;
  logic                out_free;
  logic                first_half;
  logic                edge_ovf;

  assign ep1        = ecnt + 1'b1;
  assign ep2        = ecnt + 2'd2;
  assign e_dec      = e - 1'b1;
  assign tail_dec   = tail_rd - 1'b1;
  assign sum_w      = {1'b0, dx} + (DIST_W+1)'(adj_w_rd);
  assign sum_sat    = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];
  assign parent     = (hole - 1'b1) >> 1;
  assign l2         = {1'b0, hole, 1'b1};
  assign r2         = l2 + 1'b1;
  assign l_ok       = l2 < {1'b0, hsize};
  assign r_ok       = r2 < {1'b0, hsize};
  assign hsize_dec  = hsize - 1'b1;
  assign use_l      = ahead(hp_rd0, cur);
  assign cand       = use_l ? hp_rd0 : cur;
  assign use_r      = r_ok && ahead(hp_rd1, cand);
  assign out_free   = !ovalid || rsp.ready;
  assign first_half = (state == S_EDGE1) || (state == S_EDGE2);
  assign edge_ovf   = (32'(ecnt) + 2) > ADJ_SLOTS;
  assign deq        = (state == S_IDLE) && q.valid;

  // memory control decode
  always_comb begin
    adj_we      = 1'b0;
    adj_addr    = e_dec[AW-1:0];
    adj_node_wd = qb;
    link_we     = 1'b0;
    link_addr   = e_dec[AW-1:0];
    link_wd     = '0;
    head_we     = 1'b0;
    tail_we     = 1'b0;
    head_addr   = v;
    head_wd     = '0;
    hz_we       = 1'b0;
    hz_addr     = v;
    hz_wd       = 1'b0;
    best_we     = 1'b0;
    best_addr   = v;
    best_wd     = '0;
    st_we       = 1'b0;
    st_addr     = v;
    st_wd       = LABEL_NONE;
    hp_we       = 1'b0;
    hp_waddr    = hole;
    hp_wd       = newe;
    hp_ra0      = '0;
    hp_ra1      = '0;
    unique case (state)
      S_CLR: begin
        head_we = 1'b1;
        hz_we   = 1'b1;
      end
      S_IDLE: begin
        hz_addr = NW'(q.word.a);
        hz_wd   = 1'b1;
        hz_we   = q.valid && (q.word.op == OP_HAZ);
      end
      S_EDGE1, S_EDGE3: begin
        // fresh entry ends its list
        link_we   = 1'b1;
        link_addr = first_half ? ecnt[AW-1:0] : ep1[AW-1:0];
        head_addr = first_half ? qa : qb;
      end
      S_EDGE2, S_EDGE4: begin
        adj_we      = 1'b1;
        adj_addr    = first_half ? ecnt[AW-1:0] : ep1[AW-1:0];
        adj_node_wd = first_half ? qb : qa;
        head_addr   = first_half ? qa : qb;
        head_wd     = first_half ? ep1 : ep2;
        tail_we     = 1'b1;
        link_addr   = tail_dec[AW-1:0];
        link_wd     = first_half ? ep1 : ep2;
        if (head_rd == '0) head_we = 1'b1;
        else link_we = 1'b1;
      end
      S_INIT_CK: begin
        best_we = 1'b1;
        best_wd = hz_rd ? '0 : DIST_MAX;
        st_we   = 1'b1;
      end
      S_INIT_ST: begin
        best_we   = 1'b1;
        best_addr = qa;
      end
      S_X1: begin
        st_addr   = x;
        best_addr = x;
        head_addr = x;
      end
      S_X2: begin
        st_addr = x;
        st_wd   = xh ? LABEL_HAZ : LABEL_START;
        st_we   = st_rd == LABEL_NONE;
      end
      S_E2: begin
        st_addr   = adj_node_rd;
        best_addr = adj_node_rd;
      end
      S_E3: begin
        st_addr   = tnode;
        best_addr = tnode;
        best_wd   = sum;
        best_we   = (st_rd == LABEL_NONE) && (best_rd > sum);
      end
      S_FIN1, S_FIN2: begin
        st_addr   = qb;
        best_addr = qb;
      end
      S_UP: begin
        hp_ra0 = parent;
        hp_we  = hole == '0;
      end
      S_UPW: begin
        hp_we = 1'b1;
        hp_wd = ahead(newe, hp_rd0) ? hp_rd0 : newe;
      end
      S_POP: hp_ra0 = hsize_dec[HW-1:0];
      S_DN: begin
        hp_ra0 = l2[HW-1:0];
        hp_ra1 = r2[HW-1:0];
        hp_wd  = cur;
        hp_we  = !l_ok;
      end
      S_DNW: begin
        hp_we = 1'b1;
        if (use_r) hp_wd = hp_rd1;
        else if (use_l) hp_wd = hp_rd0;
        else hp_wd = cur;
      end
      default: ;
    endcase
  end

  // adjacency memories
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_node_mem[adj_addr] <= adj_node_wd;
      adj_w_mem[adj_addr]    <= qw;
    end
    adj_node_rd <= adj_node_mem[adj_addr];
    adj_w_rd    <= adj_w_mem[adj_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_addr] <= link_wd;
    link_rd <= link_mem[link_addr];
  end

  // list head and tail
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_addr] <= head_wd;
    if (tail_we) tail_mem[head_addr] <= head_wd;
    head_rd <= head_mem[head_addr];
    tail_rd <= tail_mem[head_addr];
  end

  // per-node marks, distances and labels
  always_ff @(posedge clk) begin
    if (hz_we) hz_mem[hz_addr] <= hz_wd;
    hz_rd <= hz_mem[hz_addr];
  end

  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_addr] <= best_wd;
    best_rd <= best_mem[best_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_addr] <= st_wd;
    st_rd <= st_mem[st_addr];
  end

  // heap: one write, two reads
  always_ff @(posedge clk) begin
    if (hp_we) heap_mem[hp_waddr] <= hp_wd;
    hp_rd0 <= heap_mem[hp_ra0];
    hp_rd1 <= heap_mem[hp_ra1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      v      <= '0;
      ecnt   <= '0;
      hsize  <= '0;
      ovf    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && rsp.ready && (state != S_FIN2)) ovalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (v == V_LAST) begin
            v     <= '0;
            state <= S_IDLE;
          end else begin
            v <= v + 1'b1;
          end
        end
        S_IDLE: begin
          if (q.valid) begin
            qa  <= NW'(q.word.a);
            qb  <= NW'(q.word.b);
            qw  <= q.word.w;
            bad <= 1'b0;
            unique case (q.word.op)
              OP_HAZ: ;
              OP_EDGE: begin
                if (edge_ovf) ovf <= 1'b1;
                else state <= S_EDGE1;
              end
              OP_RUN: begin
                v     <= '0;
                state <= S_INIT_RD;
              end
              OP_RUN_BAD: begin
                bad   <= 1'b1;
                state <= S_FIN2;
              end
              default: ;
            endcase
          end
        end
        S_EDGE1: state <= S_EDGE2;
        S_EDGE2: state <= S_EDGE3;
        S_EDGE3: state <= S_EDGE4;
        S_EDGE4: begin
          ecnt  <= ep2;
          state <= S_IDLE;
        end
        S_INIT_RD: state <= S_INIT_CK;
        S_INIT_CK: begin
          if (hz_rd) begin
            newe  <= '{dval: '0, haz: 1'b1, node: v};
            ret   <= S_INIT_NX;
            state <= S_PUSH;
          end else begin
            state <= S_INIT_NX;
          end
        end
        S_INIT_NX: begin
          if (v == V_LAST) begin
            state <= S_INIT_ST;
          end else begin
            v     <= v + 1'b1;
            state <= S_INIT_RD;
          end
        end
        S_INIT_ST: begin
          newe  <= '{dval: '0, haz: 1'b0, node: qa};
          ret   <= S_TOP;
          state <= S_PUSH;
        end
        S_TOP: state <= (hsize == '0) ? S_FIN1 : S_POP0;
        S_POP0: begin
          x     <= hp_rd0.node;
          xh    <= hp_rd0.haz;
          ret   <= S_X1;
          state <= S_POP;
        end
        S_X1: state <= S_X2;
        S_X2: begin
          if (st_rd != LABEL_NONE) begin
            state <= S_TOP;
          end else begin
            dx    <= best_rd;
            e     <= head_rd;
            state <= S_E1;
          end
        end
        S_E1: state <= (e == '0) ? S_TOP : S_E2;
        S_E2: begin
          tnode <= adj_node_rd;
          sum   <= sum_sat;
          e     <= link_rd;
          state <= S_E3;
        end
        S_E3: begin
          if ((st_rd == LABEL_NONE) && (best_rd > sum)) begin
            newe  <= '{dval: sum, haz: xh, node: tnode};
            ret   <= S_E1;
            state <= S_PUSH;
          end else begin
            state <= S_E1;
          end
        end
        S_FIN1: state <= S_FIN2;
        S_FIN2: begin
          if (out_free) begin
            ovalid <= 1'b1;
            oreach <= !bad && (st_rd == LABEL_START);
            odist  <= (!bad && (st_rd == LABEL_START)) ? best_rd : '0;
            oovf   <= ovf;
            ovf    <= 1'b0;
            ecnt   <= '0;
            hsize  <= '0;
            v      <= '0;
            state  <= S_CLR;
          end
        end
        S_PUSH: begin
          if (32'(hsize) >= HEAP_SLOTS) begin
            ovf   <= 1'b1;
            state <= ret;
          end else begin
            hole  <= hsize[HW-1:0];
            hsize <= hsize + 1'b1;
            state <= S_UP;
          end
        end
        S_UP: state <= (hole == '0) ? ret : S_UPW;
        S_UPW: begin
          if (ahead(newe, hp_rd0)) begin
            hole  <= parent;
            state <= S_UP;
          end else begin
            state <= ret;
          end
        end
        S_POP: begin
          hsize <= hsize_dec;
          state <= (hsize_dec == '0) ? ret : S_POP1;
        end
        S_POP1: begin
          cur   <= hp_rd0;
          hole  <= '0;
          state <= S_DN;
        end
        S_DN: state <= l_ok ? S_DNW : ret;
        S_DNW: begin
          if (use_r) begin
            hole  <= r2[HW-1:0];
            state <= S_DN;
          end else if (use_l) begin
            hole  <= l2[HW-1:0];
            state <= S_DN;
          end else begin
            state <= ret;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  assign rsp.valid     = ovalid;
  assign rsp.reachable = oreach;
  assign rsp.distance  = odist;
  assign rsp.overflow  = oovf;

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hsize) <= HEAP_SLOTS)
    else $error("heap size beyond capacity");
  a_entries_paired: assert property (@(posedge clk) disable iff (rst)
    !ecnt[0] && (32'(ecnt) <= ADJ_SLOTS))
    else $error("edge entry count broken");
  a_result_then_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN2 && out_free) |=> (rsp.valid && state == S_CLR && !ovf && hsize == '0))
    else $error("result not followed by clearing pass");

endmodule

// File: tb/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker: scoreboard for the labelled shortest path block
// Watches the request and response channels, predicts each run result with
// its own multi-source Dijkstra search and compares it field by field.
// ----------------------------------------------------------------------------
module msp_checker import msp_pkg::*; (
  input  logic clk,
  input  logic rst,
  msp_req_if   req,
  msp_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_NODES  = 1024;
  localparam int N_SLOTS  = 2 * 4096;
  localparam int N_HEAP   = 16384;

  typedef struct {
    logic              reachable;
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } path_answer_t;

  path_answer_t answer_q[$];

  // graph model: linked adjacency lists, 0 = end of list, else index + 1
  logic [NODE_W-1:0]   link_to[N_SLOTS];
  logic [WEIGHT_W-1:0] link_w[N_SLOTS];
  int                  link_next[N_SLOTS];
  int                  head[N_NODES];
  int                  tail[N_NODES];
  int                  slot_used;
  bit                  hazard[N_NODES];
  logic [DIST_W-1:0]   best[N_NODES];
  label_t              label[N_NODES];
  bit                  dropped;

  // priority queue: distance, then hazard first, then lower node
  logic [DIST_W-1:0]   pq_dist[N_HEAP];
  int                  pq_node[N_HEAP];
  bit                  pq_haz[N_HEAP];
  int                  pq_size;

  function automatic bit pq_ahead(int i, int j);
    if (pq_dist[i] != pq_dist[j]) return pq_dist[i] < pq_dist[j];
    if (pq_haz[i] != pq_haz[j]) return pq_haz[i];
    return pq_node[i] < pq_node[j];
  endfunction

  function automatic void pq_swap(int i, int j);
    logic [DIST_W-1:0] d;
    int n;
    bit h;
    d = pq_dist[i]; pq_dist[i] = pq_dist[j]; pq_dist[j] = d;
    n = pq_node[i]; pq_node[i] = pq_node[j]; pq_node[j] = n;
    h = pq_haz[i]; pq_haz[i] = pq_haz[j]; pq_haz[j] = h;
  endfunction

  function automatic void pq_push(int node, logic [DIST_W-1:0] d, bit h);
    int i;
    if (pq_size >= N_HEAP) begin
      dropped = 1'b1;
      return;
    end
    i = pq_size;
    pq_size++;
    pq_node[i] = node; pq_dist[i] = d; pq_haz[i] = h;
    while (i > 0 && pq_ahead(i, (i - 1) / 2)) begin
      pq_swap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  function automatic void pq_pop();
    int i, l, m;
    i = 0;
    pq_size--;
    if (pq_size == 0) return;
    pq_swap(0, pq_size);
    forever begin
      l = 2 * i + 1;
      m = i;
      if (l < pq_size && pq_ahead(l, m)) m = l;
      if (l + 1 < pq_size && pq_ahead(l + 1, m)) m = l + 1;
      if (m == i) break;
      pq_swap(i, m);
      i = m;
    end
  endfunction

  function automatic void link_add(int from, int to, logic [WEIGHT_W-1:0] w);
    int e;
    e = slot_used;
    slot_used++;
    link_to[e] = to; link_w[e] = w; link_next[e] = 0;
    if (head[from] == 0) head[from] = e + 1;
    else link_next[tail[from] - 1] = e + 1;
    tail[from] = e + 1;
  endfunction

  function automatic void clear_graph();
    for (int v = 0; v < N_NODES; v++) begin
      head[v] = 0; tail[v] = 0; hazard[v] = 0; label[v] = LABEL_NONE;
    end
    slot_used = 0;
    pq_size = 0;
    dropped = 0;
  endfunction

  // search from all hazards and the start, answer for the finish node
  function automatic path_answer_t shortest_path(int start, int finish);
    path_answer_t ans;
    int x, e, to;
    bit h;
    logic [DIST_W:0] sum;
    for (int v = 0; v < N_NODES; v++) begin
      best[v] = DIST_MAX; label[v] = LABEL_NONE;
    end
    pq_size = 0;
    for (int v = 0; v < N_NODES; v++)
      if (hazard[v]) begin
        pq_push(v, '0, 1'b1);
        best[v] = '0;
      end
    pq_push(start, '0, 1'b0);
    best[start] = '0;
    while (pq_size > 0) begin
      x = pq_node[0];
      h = pq_haz[0];
      pq_pop();
      if (label[x] != LABEL_NONE) continue;
      label[x] = h ? LABEL_HAZ : LABEL_START;
      e = head[x];
      while (e != 0) begin
        to = link_to[e - 1];
        sum = {1'b0, best[x]} + link_w[e - 1];
        if (sum > DIST_MAX) sum = DIST_MAX;
        if (label[to] == LABEL_NONE && best[to] > sum[DIST_W-1:0]) begin
          best[to] = sum[DIST_W-1:0];
          pq_push(to, sum[DIST_W-1:0], h);
        end
        e = link_next[e - 1];
      end
    end
    ans.reachable = (label[finish] == LABEL_START);
    ans.distance  = ans.reachable ? best[finish] : '0;
    ans.overflow  = dropped;
    return ans;
  endfunction

  initial begin
    fail_count = 0;
    clear_graph();
  end

  assign pending = answer_q.size();

  // request side: update the graph model, queue an answer per run
  always @(posedge clk) begin
    path_answer_t run_a;
    if (!rst && req.valid && req.ready) begin
      case (req.cmd)
        CMD_HAZ:  hazard[req.node_a] = 1'b1;
        CMD_EDGE: begin
          if (slot_used + 2 > N_SLOTS) dropped = 1'b1;
          else begin
            link_add(req.node_a, req.node_b, req.weight);
            link_add(req.node_b, req.node_a, req.weight);
          end
        end
        CMD_RUN: begin
          run_a = shortest_path(req.node_a, req.node_b);
          answer_q = {answer_q, run_a};
          clear_graph();
        end
        default: ;
      endcase
    end
  end

  // response side: compare with the oldest answer
  always @(posedge clk) begin
    path_answer_t exp_a;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result reachable=%0d distance=%0d overflow=%0d",
                 $time, rsp.reachable, rsp.distance, rsp.overflow);
        fail_count++;
      end else begin
        exp_a = answer_q.pop_front();
        if (rsp.reachable !== exp_a.reachable) begin
          $display("%0t: reachable expected %0d actual %0d", $time,
                   exp_a.reachable, rsp.reachable);
          fail_count++;
        end
        if (rsp.distance !== exp_a.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   exp_a.distance, rsp.distance);
          fail_count++;
        end
        if (rsp.overflow !== exp_a.overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $time,
                   exp_a.overflow, rsp.overflow);
          fail_count++;
        end
      end
    end
  end

endmodule

// File: tb/tb_multi_source_labelled_shortest_path.sv
// ----------------------------------------------------------------------------
// tb_multi_source_labelled_shortest_path: regression for the path block
// Drives hazard, edge, run and unused command words (directed corner cases
// and random small graphs) under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_multi_source_labelled_shortest_path;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_NOP    = 3;
  localparam int RAND_WORDS = 1000;
  localparam int CYCLE_CAP  = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   send_idle = 14;
  int   recv_idle = 50;
  int   sent = 0;
  bit   hold_off = 1'b0;
  int   cycles = 0;

  msp_req_if req_ch ();
  msp_rsp_if rsp_ch ();

  multi_source_labelled_shortest_path u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  msp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("multi_source_labelled_shortest_path regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (rst || hold_off) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // long enough to outlast a full run, so the queue fills behind it
  initial begin
    wait (sent >= 120);
    hold_off = 1'b1;
    repeat (20000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic put(input int c, input int a, input int b, input logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.cmd    <= c[CMD_W-1:0];
    req_ch.node_a <= a[NODE_W-1:0];
    req_ch.node_b <= b[NODE_W-1:0];
    req_ch.weight <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return $urandom_range(1000);
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(20);
    endcase
  endfunction

  initial begin
    int base, span, nh, ne, haz_node, start, finish, rand_cnt;
    req_ch.valid  = 1'b0;
    req_ch.cmd    = '0;
    req_ch.node_a = '0;
    req_ch.node_b = '0;
    req_ch.weight = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner cases: extreme nodes and weights, start on a hazard,
    // repeated hazard, unused command, start equal to finish, unreachable
    put(CMD_HAZ, 0, 0, 0);
    put(CMD_HAZ, 0, 0, 0);
    put(CMD_EDGE, 0, 1023, 32'hFFFF_FFFF);
    put(CMD_EDGE, 1023, 512, 0);
    put(CMD_NOP, 1023, 1023, 32'hFFFF_FFFF);
    put(CMD_RUN, 0, 1023, 0);
    put(CMD_EDGE, 1023, 0, 32'hFFFF_FFFF);
    put(CMD_EDGE, 0, 341, 5);
    put(CMD_EDGE, 341, 1023, 7);
    put(CMD_RUN, 1023, 0, 0);
    put(CMD_RUN, 682, 682, 32'hFFFF_FFFF);
    put(CMD_HAZ, 1023, 0, 0);
    put(CMD_EDGE, 5, 6, 1);
    put(CMD_EDGE, 6, 1023, 1);
    put(CMD_EDGE, 5, 5, 3);
    put(CMD_RUN, 5, 6, 0);
    put(CMD_RUN, 5, 1023, 0);
    put(CMD_HAZ, 10, 0, 0);
    put(CMD_EDGE, 10, 11, 4);
    put(CMD_EDGE, 12, 11, 4);
    put(CMD_RUN, 12, 11, 0);

    // random small graphs, each closed by a run
    rand_cnt = 0;
    while (rand_cnt < RAND_WORDS) begin
      if (rand_cnt < RAND_WORDS / 3) begin
        send_idle = 14; recv_idle = 50;
      end else if (rand_cnt < 2 * RAND_WORDS / 3) begin
        send_idle = 50; recv_idle = 14;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      span = ($urandom_range(9) == 0) ? 1023 : 15;
      base = (span == 1023) ? 0 : $urandom_range(1023 - span);
      nh = $urandom_range(3);
      ne = $urandom_range(14);
      haz_node = base + $urandom_range(span);
      for (int i = 0; i < nh; i++) begin
        haz_node = base + $urandom_range(span);
        put(CMD_HAZ, haz_node, $urandom_range(1023), $urandom);
        rand_cnt++;
      end
      for (int i = 0; i < ne; i++) begin
        if ($urandom_range(15) == 0) put(CMD_NOP, $urandom_range(1023),
                                         $urandom_range(1023), $urandom);
        put(CMD_EDGE, base + $urandom_range(span), base + $urandom_range(span),
            rand_weight());
        rand_cnt++;
      end
      start  = (nh > 0 && $urandom_range(5) == 0) ? haz_node
                                                  : base + $urandom_range(span);
      finish = ($urandom_range(7) == 0) ? start : base + $urandom_range(span);
      put(CMD_RUN, start, finish, $urandom);
      rand_cnt++;
    end

    put(CMD_EDGE, 1, 2, 3);
    put(CMD_RUN, 1, 2, 0);
    req_ch.valid <= 1'b0;

    // drain, then allow for the clearing pass
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0)
      $display("multi_source_labelled_shortest_path regression: pass");
    else
      $display("multi_source_labelled_shortest_path regression: fail");
    $finish;
  end

endmodule
